// ===== rtl/bcaf_pkg.sv =====
// Shared constants and the controller-to-datapath command bundle for the
// per-base channel area feature block. No dependencies.
package bcaf_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned AREA_BITS_DEF       = 32;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 16;

  // Fixed width of one channel field on the input bus
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned NUM_CH     = 4;

  typedef struct packed {
    logic acc_en;      // add the accepted sample into the accumulators
    logic snap;        // window closes: move areas to snapshot, clear accumulators
    logic sort_en;     // order the four snapshot areas
    logic sum_en;      // form low and high pair sums
    logic div_init;    // integer quotient bit and first remainder
    logic div_step;    // one fraction bit of the ratio
    logic out_load;    // load the result register
  } bcaf_cmd_t;

endpackage

// ===== rtl/bcaf_datapath.sv =====
// Datapath: saturating channel accumulators, snapshot, sorting network,
// pair sums, bit-serial fraction divider and result register. Uses bcaf_pkg.
module bcaf_datapath import bcaf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int unsigned AREA_BITS       = AREA_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcaf_cmd_t                     cmd_i,
  input  logic [NUM_CH*FIELD_BITS-1:0]  samples_i,
  output logic [AREA_BITS+1:0]          area_sum_o,
  output logic [AREA_BITS-1:0]          largest_area_o,
  output logic [RATIO_FRAC_BITS:0]      half_signal_ratio_o
);

  localparam int unsigned A = AREA_BITS;
  localparam int unsigned F = RATIO_FRAC_BITS;

  logic [A-1:0] acc_q  [NUM_CH];
  logic [A-1:0] sat_d  [NUM_CH];
  logic [A-1:0] snap_q [NUM_CH];
  logic [A-1:0] srt_d  [NUM_CH];
  logic [A-1:0] srt_q  [NUM_CH];

  logic [A:0]   low_q, high_q;
  logic [A-1:0] big_q;
  logic [A:0]   rem_q;
  logic [F:0]   quo_q;
  logic [A+1:0] rem_sh;
  logic [A+1:0] rem_sub;
  logic         rem_ge;
  logic [F:0]   ratio_d;

  logic [A+1:0] total_q;
  logic [A-1:0] largest_q;
  logic [F:0]   ratio_q;

  function automatic logic [A-1:0] fmin(input logic [A-1:0] x, input logic [A-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [A-1:0] fmax(input logic [A-1:0] x, input logic [A-1:0] y);
    return (x < y) ? y : x;
  endfunction

  // Saturating add of the low SAMPLE_BITS of each channel
  always_comb begin
    logic [FIELD_BITS-1:0] fld;
    logic [A:0]            sum;
    for (int i = 0; i < NUM_CH; i++) begin
      fld      = samples_i[i*FIELD_BITS +: FIELD_BITS];
      sum      = {1'b0, acc_q[i]} + (A+1)'(fld[SAMPLE_BITS-1:0]);
      sat_d[i] = sum[A] ? '1 : sum[A-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) acc_q[i] <= '0;
    end else if (cmd_i.acc_en) begin
      for (int i = 0; i < NUM_CH; i++) acc_q[i] <= cmd_i.snap ? '0 : sat_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      for (int i = 0; i < NUM_CH; i++) snap_q[i] <= sat_d[i];
    end
  end

  // Five compare-exchanges: full sort of four values
  always_comb begin
    logic [A-1:0] l0, h0, l1, h1, x, y;
    l0       = fmin(snap_q[0], snap_q[1]);
    h0       = fmax(snap_q[0], snap_q[1]);
    l1       = fmin(snap_q[2], snap_q[3]);
    h1       = fmax(snap_q[2], snap_q[3]);
    srt_d[0] = fmin(l0, l1);
    x        = fmax(l0, l1);
    y        = fmin(h0, h1);
    srt_d[3] = fmax(h0, h1);
    srt_d[1] = fmin(x, y);
    srt_d[2] = fmax(x, y);
  end

  // Restoring divider, one quotient bit per step; rem stays below a nonzero high
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, high_q};
  assign rem_sub = rem_sh - {1'b0, high_q};

  always_comb begin
    ratio_d = quo_q;
    if (high_q == '0) begin
      ratio_d    = '0;
      ratio_d[F] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_en) begin
      for (int i = 0; i < NUM_CH; i++) srt_q[i] <= srt_d[i];
    end
    if (cmd_i.sum_en) begin
      low_q  <= {1'b0, srt_q[0]} + {1'b0, srt_q[1]};
      high_q <= {1'b0, srt_q[2]} + {1'b0, srt_q[3]};
      big_q  <= srt_q[3];
    end
    if (cmd_i.div_init) begin
      quo_q <= (F+1)'(low_q >= high_q);
      rem_q <= (low_q >= high_q) ? low_q - high_q : low_q;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[F-1:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[A:0] : rem_sh[A:0];
    end
    if (cmd_i.out_load) begin
      total_q   <= {1'b0, low_q} + {1'b0, high_q};
      largest_q <= big_q;
      ratio_q   <= ratio_d;
    end
  end

  assign area_sum_o          = total_q;
  assign largest_area_o      = largest_q;
  assign half_signal_ratio_o = ratio_q;

endmodule

// ===== rtl/bcaf_ctrl.sv =====
// Controller: window-end sequencing (sort, sums, divide), fraction bit counter
// and output valid. Drives bcaf_datapath through bcaf_cmd_t from bcaf_pkg.
module bcaf_ctrl import bcaf_pkg::*; #(
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bcaf_cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(RATIO_FRAC_BITS + 1);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SORT,
    ST_SUM,
    ST_INIT,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             m_valid_q, m_valid_d;
  logic             out_free;

  assign out_free   = !m_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_ACC);

  always_comb begin
    cmd_o          = '0;
    state_d        = state_q;
    cnt_d          = cnt_q;
    m_valid_d      = m_valid_q && !out_ready_i;
    cmd_o.acc_en   = in_valid_i && in_ready_o;
    cmd_o.snap     = cmd_o.acc_en && in_last_i;
    unique case (state_q)
      ST_ACC: begin
        if (cmd_o.snap) state_d = ST_SORT;
      end
      ST_SORT: begin
        cmd_o.sort_en = 1'b1;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RATIO_FRAC_BITS - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACC;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign out_valid_o = m_valid_q;

  // Result register is never overwritten while a result still waits
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!m_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_snap_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.snap |=> (state_q == ST_SORT))
    else $error("window close did not start sort");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid without finished divide");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < CNT_W'(RATIO_FRAC_BITS)))
    else $error("divide step count overrun");

endmodule

// ===== rtl/per_base_channel_area_features_core.sv =====
// Channel    Dir  Fields (low bit first)                          Accept
// s_axis     in   tdata: c[15:0] g[31:16] a[47:32] t[63:48]        tvalid & tready
//                 tlast: last_in_window
// m_axis     out  tdata: area_sum, largest_area, half_signal_ratio   tvalid & tready
//
// Samples are accepted one per cycle. A request with tlast set closes the
// window; input is then held off through the sort, pair sums, divider
// setup, one step per fraction bit of the serial divider and result load,
// longer if the previous result has not been taken.
// Reset (rst_ni, async, active low) clears the accumulators and output valid.
// Top level; uses bcaf_pkg, bcaf_ctrl, bcaf_datapath.
module per_base_channel_area_features_core import bcaf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int unsigned AREA_BITS       = AREA_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
  localparam int unsigned OUT_BITS  = 2 * AREA_BITS + RATIO_FRAC_BITS + 3,
  localparam int unsigned OUT_TDATA = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // sample_c, sample_g, sample_a, sample_t
  input  logic [NUM_CH*FIELD_BITS-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // area_sum, largest_area, half_signal_ratio, zero fill
  output logic [OUT_TDATA-1:0]         m_axis_tdata_o
);

  bcaf_cmd_t                  cmd;
  logic [AREA_BITS+1:0]       area_sum;
  logic [AREA_BITS-1:0]       largest_area;
  logic [RATIO_FRAC_BITS:0]   half_signal_ratio;

  bcaf_ctrl #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd)
  );

  bcaf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .AREA_BITS      (AREA_BITS),
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .samples_i          (s_axis_tdata_i),
    .area_sum_o         (area_sum),
    .largest_area_o     (largest_area),
    .half_signal_ratio_o(half_signal_ratio)
  );

  assign m_axis_tdata_o = OUT_TDATA'({half_signal_ratio, largest_area, area_sum});

endmodule
